FILE: hdl/b64u_pkg.sv
// ----------------------------------------------------------------------------
// b64u_pkg
// Shared types, constants and the sextet-to-ASCII mapping for the
// base64url encoder.
// ----------------------------------------------------------------------------
package b64u_pkg;

    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_word_t;

    typedef struct packed {
        logic [6:0] char_code;
        logic       last_char;
    } char_word_t;

    typedef enum logic [1:0] {
        PH_0 = 2'd0,
        PH_1 = 2'd1,
        PH_2 = 2'd2
    } phase_t;

    typedef enum logic {
        BK_FIRST  = 1'b0,
        BK_SECOND = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [5:0] sextet0;
        logic [5:0] sextet1;
        logic       two;
        logic       mark;
    } group_t;

    typedef struct packed {
        phase_t     phase;
        logic [1:0] unused_pad;
    } front_status_t;

    localparam logic [6:0] CH_UPPER_A = 7'd65;
    localparam logic [6:0] CH_LOWER_OFS = 7'd71;
    localparam logic [6:0] CH_DIGIT_OFS = 7'd4;
    localparam logic [6:0] CH_DASH = 7'd45;
    localparam logic [6:0] CH_UNDERSCORE = 7'd95;

    function automatic logic [6:0] sextet_to_ascii(input logic [5:0] s);
        logic [6:0] c;
        if (s < 6'd26)
            c = {1'b0, s} + CH_UPPER_A;
        else if (s < 6'd52)
            c = {1'b0, s} + CH_LOWER_OFS;
        else if (s < 6'd62)
            c = {1'b0, s} - CH_DIGIT_OFS;
        else if (s == 6'd62)
            c = CH_DASH;
        else
            c = CH_UNDERSCORE;
        return c;
    endfunction

endpackage

FILE: hdl/base64url_encoder.sv
// ----------------------------------------------------------------------------
// base64url_encoder
// Streaming URL-safe base64 encoder without padding.
// ----------------------------------------------------------------------------
// Input channel byte_valid/byte_ready/byte_word carries one message byte
// and a flag marking the last byte of the message. Output channel
// char_valid/char_ready/char_word carries one ASCII character and a flag
// on the final character of the encoded message.
// Each byte gives one or two characters; a full three-byte group gives
// four. The output side moves one character per cycle while the receiver
// is ready, so a byte that yields two characters holds the output for
// both, and the queue takes new bytes while earlier characters drain.
// The first character of a byte passes from the queue entry into the
// output register, where the receiver can take it. A two-entry queue
// separates byte intake from character output, so intake continues
// while a character waits.
// Reset clears the group phase, the queue and the output valid flag; the
// next byte starts a new message. When the receiver stalls, the output
// character is held, the queue fills, and byte_ready drops.
// ----------------------------------------------------------------------------
module base64url_encoder (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_valid,
    output logic                 byte_ready,
    input  b64u_pkg::byte_word_t byte_word,
    output logic                 char_valid,
    input  logic                 char_ready,
    output b64u_pkg::char_word_t char_word
);
    import b64u_pkg::*;

    group_t              q_in, q_head;
    logic                q_push, q_pop, q_full, q_empty;
    logic [QCOUNT_W-1:0] q_count;
    front_status_t       f_status;

    b64u_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_data     (q_in),
        .status     (f_status)
    );

    b64u_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty),
        .count     (q_count)
    );

    b64u_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word)
    );

    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        q_count <= QCOUNT_W'(QDEPTH))
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("pop from empty queue");

    a_phase_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && byte_word.last_byte) |=> (f_status.phase == PH_0))
        else $error("group phase not cleared after last byte");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (q_push && !q_pop) |=> (q_count == $past(q_count) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

FILE: hdl/b64u_front.sv
// ----------------------------------------------------------------------------
// b64u_front
// Accepts message bytes, tracks the group phase and leftover bits, and
// turns each byte into a group entry of one or two sextets.
// ----------------------------------------------------------------------------
module b64u_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   byte_valid,
    output logic                   byte_ready,
    input  b64u_pkg::byte_word_t   byte_word,
    input  logic                   q_full,
    output logic                   q_push,
    output b64u_pkg::group_t       q_data,
    output b64u_pkg::front_status_t status
);
    import b64u_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [3:0] left_reg, left_next;
    logic [7:0] b;
    logic       last;

    assign b          = byte_word.data_byte;
    assign last       = byte_word.last_byte;
    assign byte_ready = !q_full;
    assign q_push     = byte_valid && !q_full;
    assign status     = '{phase: phase_reg, unused_pad: 2'b00};

    always_comb
    begin
        q_data     = '0;
        phase_next = phase_reg;
        left_next  = left_reg;
        unique case (phase_reg)
            PH_1:
            begin
                q_data.sextet0 = {left_reg[1:0], b[7:4]};
                if (last)
                begin
                    q_data.sextet1 = {b[3:0], 2'b00};
                    q_data.two     = 1'b1;
                    q_data.mark    = 1'b1;
                    phase_next     = PH_0;
                    left_next      = 4'd0;
                end
                else
                begin
                    phase_next = PH_2;
                    left_next  = b[3:0];
                end
            end
            PH_2:
            begin
                q_data.sextet0 = {left_reg, b[7:6]};
                q_data.sextet1 = b[5:0];
                q_data.two     = 1'b1;
                q_data.mark    = last;
                phase_next     = PH_0;
                left_next      = 4'd0;
            end
            default:
            begin
                q_data.sextet0 = b[7:2];
                if (last)
                begin
                    q_data.sextet1 = {b[1:0], 4'b0000};
                    q_data.two     = 1'b1;
                    q_data.mark    = 1'b1;
                    phase_next     = PH_0;
                    left_next      = 4'd0;
                end
                else
                begin
                    phase_next = PH_1;
                    left_next  = {2'b00, b[1:0]};
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_0;
            left_reg  <= 4'd0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            left_reg  <= left_next;
        end
    end

endmodule

FILE: hdl/b64u_queue.sv
// ----------------------------------------------------------------------------
// b64u_queue
// Short FIFO of group entries between the front and back parts.
// ----------------------------------------------------------------------------
module b64u_queue (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  b64u_pkg::group_t                  push_data,
    input  logic                              pop,
    output b64u_pkg::group_t                  head,
    output logic                              full,
    output logic                              empty,
    output logic [b64u_pkg::QCOUNT_W-1:0]     count
);
    import b64u_pkg::*;

    group_t              entry_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCOUNT_W-1:0] count_reg, count_next;

    assign head  = entry_reg[rd_ptr_reg];
    assign full  = (count_reg == QCOUNT_W'(QDEPTH));
    assign empty = (count_reg == '0);
    assign count = count_reg;

    always_comb
    begin
        wr_ptr_next = push ? QPTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop  ? QPTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: hdl/b64u_back.sv
// ----------------------------------------------------------------------------
// b64u_back
// Drains group entries one sextet per cycle while the receiver takes them,
// maps each to its ASCII character, held in the output register until taken.
// ----------------------------------------------------------------------------
module b64u_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  b64u_pkg::group_t     head,
    input  logic                 q_empty,
    output logic                 q_pop,
    output logic                 char_valid,
    input  logic                 char_ready,
    output b64u_pkg::char_word_t char_word
);
    import b64u_pkg::*;

    back_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    char_word_t  out_word_reg, out_word_next;
    logic        load;
    logic [5:0]  sextet;

    assign char_valid = out_valid_reg;
    assign char_word  = out_word_reg;
    assign load       = !q_empty && (!out_valid_reg || char_ready);

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !char_ready;
        out_word_next  = out_word_reg;
        q_pop          = 1'b0;
        sextet         = head.sextet0;
        unique case (state_reg)
            BK_SECOND:
            begin
                sextet = head.sextet1;
                if (load)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.char_code = sextet_to_ascii(sextet);
                    out_word_next.last_char = head.mark;
                    q_pop                   = 1'b1;
                    state_next              = BK_FIRST;
                end
            end
            default:
            begin
                if (load)
                begin
                    out_valid_next          = 1'b1;
                    out_word_next.char_code = sextet_to_ascii(sextet);
                    out_word_next.last_char = head.mark && !head.two;
                    if (head.two)
                        state_next = BK_SECOND;
                    else
                        q_pop = 1'b1;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
    end

endmodule

FILE: tb/tb_base64url_encoder.sv
// ----------------------------------------------------------------------------
// tb_base64url_encoder
// Self-checking bench for the streaming base64url encoder without padding.
// ----------------------------------------------------------------------------
// Messages of random length and content go in one byte word at a time. A
// behavioral encoder predicts the character words that each accepted byte
// completes, and every character word that leaves the block is compared,
// field by field, with the oldest prediction. The sender and the receiver
// both pause at random. A quiet stretch runs at full rate, and a long
// receiver hold-off fills the block until it stalls its input.
// ----------------------------------------------------------------------------
module tb_base64url_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    import b64u_pkg::*;

    localparam int IDLE_PCT = 19;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       byte_valid = 1'b0;
    logic       byte_ready;
    byte_word_t byte_word = '0;
    logic       char_valid;
    logic       char_ready = 1'b0;
    char_word_t char_word;

    string      url_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789-_";

    phase_t     enc_phase = PH_0;
    logic [3:0] enc_leftover = '0;
    char_word_t pending_chars[$];

    bit         idle_on = 1'b1;
    int         hold_cycles = 0;
    int         mismatches = 0;
    int         bytes_sent = 0;

    base64url_encoder uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_word  (byte_word),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_word  (char_word)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("%0t ns: %s mismatch: got %0d, want %0d", $time, what, got, want);
    endtask

    task automatic push_char(input logic [5:0] sextet, input logic mark);
        char_word_t w;
        byte        ch;
        ch = url_alphabet[sextet];
        w.char_code = ch[6:0];
        w.last_char = mark;
        pending_chars.insert(pending_chars.size(), w);
    endtask

    task automatic encode_byte(input logic [7:0] b, input logic lst);
        case (enc_phase)
            PH_1:
            begin
                push_char({enc_leftover[1:0], b[7:4]}, 1'b0);
                if (lst)
                begin
                    push_char({b[3:0], 2'b00}, 1'b1);
                    enc_phase = PH_0;
                    enc_leftover = '0;
                end
                else
                begin
                    enc_phase = PH_2;
                    enc_leftover = b[3:0];
                end
            end
            PH_2:
            begin
                push_char({enc_leftover, b[7:6]}, 1'b0);
                push_char(b[5:0], lst);
                enc_phase = PH_0;
                enc_leftover = '0;
            end
            default:
            begin
                push_char(b[7:2], 1'b0);
                if (lst)
                begin
                    push_char({b[1:0], 4'b0000}, 1'b1);
                    enc_phase = PH_0;
                    enc_leftover = '0;
                end
                else
                begin
                    enc_phase = PH_1;
                    enc_leftover = {2'b00, b[1:0]};
                end
            end
        endcase
    endtask

    // Receiver: check the accepted word, then drive ready for the next edge.
    always @(posedge clk)
    begin
        char_word_t want;
        if (rst_n && char_valid && char_ready)
        begin
            if (pending_chars.size() == 0)
                report_mismatch("unexpected word", char_word, 0);
            else
            begin
                want = pending_chars.pop_front();
                if (char_word.char_code !== want.char_code)
                    report_mismatch("char_code", char_word.char_code, want.char_code);
                if (char_word.last_char !== want.last_char)
                    report_mismatch("last_char", char_word.last_char, want.last_char);
            end
        end
        if (hold_cycles > 0)
        begin
            char_ready <= 1'b0;
            hold_cycles--;
        end
        else
            char_ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
    end

    task automatic send_byte(input logic [7:0] b, input logic lst);
        if (idle_on)
        begin
            while ($urandom_range(99) < IDLE_PCT)
            begin
                byte_valid <= 1'b0;
                @(posedge clk);
            end
        end
        byte_valid <= 1'b1;
        byte_word <= '{data_byte: b, last_byte: lst};
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        encode_byte(b, lst);
        bytes_sent++;
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(255)), i == len - 1);
    endtask

    function automatic int pick_length();
        if ($urandom_range(9) == 0)
            return $urandom_range(48, 13);
        return $urandom_range(12, 1);
    endfunction

    task automatic wait_drain();
        while (pending_chars.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_messages();
        logic [7:0] msgs[9][$];
        msgs[0] = '{8'h00};
        msgs[1] = '{8'hFF};
        msgs[2] = '{8'hF8};
        msgs[3] = '{8'h00, 8'hFF};
        msgs[4] = '{8'hFF, 8'h00};
        msgs[5] = '{8'h00, 8'h00, 8'h00};
        msgs[6] = '{8'hFF, 8'hFF, 8'hFF};
        msgs[7] = '{8'hFB, 8'hEF, 8'hBE};
        msgs[8] = '{8'h4D, 8'h61, 8'h6E, 8'h4D};
        foreach (msgs[m])
            foreach (msgs[m][i])
                send_byte(msgs[m][i], i == msgs[m].size() - 1);
    endtask

    task automatic test_random_messages(input int goal);
        int start_count;
        start_count = bytes_sent;
        while (bytes_sent - start_count < goal)
            send_message(pick_length());
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        test_random_messages(60);
        idle_on = 1'b1;
    endtask

    task automatic test_receiver_hold();
        idle_on = 1'b0;
        hold_cycles = 150;
        send_message(17);
        send_message(13);
        idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_messages();
        test_random_messages(300);
        test_full_rate();
        test_receiver_hold();
        test_random_messages(260);

        byte_valid <= 1'b0;
        wait_drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/b64u_pkg.sv
hdl/b64u_front.sv
hdl/b64u_queue.sv
hdl/b64u_back.sv
hdl/base64url_encoder.sv
tb/tb_base64url_encoder.sv
